FILE: rtl/core/ccs_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream cipher.
// Used by ccs_block_core and chacha20_stream_cipher; depends on nothing else.
package ccs_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } qr_t;

    localparam int ROUND_COUNT = 20;
    localparam int ROUND_CNT_W = $clog2(ROUND_COUNT);

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    localparam word_t COUNTER_LIMIT = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int DATA_W     = 64;
    localparam int COUNT_W    = 4;
    localparam int WORDS_W    = 3;
    localparam int BYTES_PER_WORD = DATA_W / 8;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CTR = 3'd6;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FEED
    } core_state_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_BLOCK,
        CTL_EMIT
    } ctl_state_t;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic qr_t quarter_round(word_t a_in, word_t b_in, word_t c_in, word_t d_in);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return '{a: a, b: b, c: c, d: d};
    endfunction

    // One column round, or one diagonal round when diag is set: four
    // independent quarter rounds on disjoint words of the state.
    function automatic state_t chacha_round(state_t x, logic diag);
        state_t     y;
        qr_t        q;
        logic [1:0] ib;
        logic [1:0] ic;
        logic [1:0] id;
        y = x;
        for (int i = 0; i < 4; i++) begin
            ib = diag ? 2'(i + 1) : 2'(i);
            ic = diag ? 2'(i + 2) : 2'(i);
            id = diag ? 2'(i + 3) : 2'(i);
            q = quarter_round(x[i], x[{2'd1, ib}], x[{2'd2, ic}], x[{2'd3, id}]);
            y[i]            = q.a;
            y[{2'd1, ib}]   = q.b;
            y[{2'd2, ic}]   = q.c;
            y[{2'd3, id}]   = q.d;
        end
        return y;
    endfunction

endpackage

FILE: rtl/core/ccs_block_core.sv
// Iterative ChaCha20 block function: one shared round unit, twenty passes,
// then a feed-forward add. Depends on ccs_pkg.
module ccs_block_core
    import ccs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  state_t init_state,
    output logic   done,
    output state_t keystream
);

    core_state_t            state_reg, state_next;
    logic [ROUND_CNT_W-1:0] round_cnt_reg, round_cnt_next;
    state_t                 x_reg, x_next;
    state_t                 init_reg;
    logic                   last_round;

    assign last_round = (round_cnt_reg == ROUND_CNT_W'(ROUND_COUNT - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:  if (start) state_next = CORE_ROUND;
            CORE_ROUND: if (last_round) state_next = CORE_FEED;
            CORE_FEED:  state_next = CORE_IDLE;
            default:    state_next = CORE_IDLE;
        endcase
    end

    always_comb begin
        round_cnt_next = round_cnt_reg;
        x_next         = x_reg;
        done           = 1'b0;
        unique case (state_reg)
            CORE_IDLE: begin
                if (start) begin
                    x_next         = init_state;
                    round_cnt_next = '0;
                end
            end
            CORE_ROUND: begin
                // Even passes work on columns, odd passes on diagonals.
                x_next         = chacha_round(x_reg, round_cnt_reg[0]);
                round_cnt_next = round_cnt_reg + 1'b1;
            end
            CORE_FEED: begin
                for (int i = 0; i < 16; i++) begin
                    x_next[i] = x_reg[i] + init_reg[i];
                end
                done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CORE_IDLE;
            round_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        if (state_reg == CORE_IDLE && start) begin
            init_reg <= init_state;
        end
    end

    // The working state doubles as the keystream buffer; it is only
    // overwritten when the next block is started.
    assign keystream = x_reg;

endmodule

FILE: rtl/core/chacha20_stream_cipher.sv
// ChaCha20 stream cipher over 8-byte beats. A beat that opens a keystream block
// reaches the output register after one load, twenty rounds on the shared round
// unit and one feed-forward add; other beats go straight to the output register.
// A new beat is taken only once the previous one has been written to the output
// register. Reset (aresetn, synchronous, active low) clears the configuration,
// the block counter and the word position.
module chacha20_stream_cipher
    import ccs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input beats.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,   // [63:0] data_in, [67:64] byte_count, [71:68] zero
    input  logic                 s_tlast,   // last_of_message

    // Result beats.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [63:0] data_out
    output logic [0:0]           m_tuser,   // [0] overflow_error
    output logic                 m_tlast,   // last_out

    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [63:0]          cfg_wdata
);

    // Configuration registers.
    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg;
    logic [63:0] nonce_lo_reg;
    word_t       nonce_hi_reg;
    word_t       counter_reg;
    logic        cfg_write;

    // Sequencer and buffered input beat.
    ctl_state_t          state_reg, state_next;
    logic [WORDS_W-1:0]  wp_reg;
    logic [DATA_W-1:0]   data_hold_reg;
    logic [COUNT_W-1:0]  count_hold_reg;
    logic                last_hold_reg;
    logic                ovf_hold_reg;

    // Output register.
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_data_reg;
    logic                m_err_reg;
    logic                m_last_reg;

    logic   accept;
    logic   need_block;
    logic   overflow;
    logic   core_start;
    logic   core_done;
    logic   out_free;
    logic   emit_fire;
    state_t init_state;
    state_t keystream;
    logic [DATA_W-1:0] ks_word;
    logic [DATA_W-1:0] byte_mask;
    logic [DATA_W-1:0] result_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key01_reg    <= '0;
            key23_reg    <= '0;
            key45_reg    <= '0;
            key67_reg    <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_addr)
                CFG_KEY_01:   key01_reg    <= cfg_wdata;
                CFG_KEY_23:   key23_reg    <= cfg_wdata;
                CFG_KEY_45:   key45_reg    <= cfg_wdata;
                CFG_KEY_67:   key67_reg    <= cfg_wdata;
                CFG_NONCE_LO: nonce_lo_reg <= cfg_wdata;
                CFG_NONCE_HI: nonce_hi_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // The block counter is reloaded by a start counter write and advances by
    // one each time a block is generated. An exhausted counter is left as is.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
        end else if (cfg_write && cfg_addr == CFG_START_CTR) begin
            counter_reg <= cfg_wdata[31:0];
        end else if (core_start) begin
            counter_reg <= counter_reg + 32'd1;
        end
    end

    // Initial ChaCha state: constants, key, counter, nonce.
    always_comb begin
        init_state[0]  = SIGMA_0;
        init_state[1]  = SIGMA_1;
        init_state[2]  = SIGMA_2;
        init_state[3]  = SIGMA_3;
        init_state[4]  = key01_reg[31:0];
        init_state[5]  = key01_reg[63:32];
        init_state[6]  = key23_reg[31:0];
        init_state[7]  = key23_reg[63:32];
        init_state[8]  = key45_reg[31:0];
        init_state[9]  = key45_reg[63:32];
        init_state[10] = key67_reg[31:0];
        init_state[11] = key67_reg[63:32];
        init_state[12] = counter_reg;
        init_state[13] = nonce_lo_reg[31:0];
        init_state[14] = nonce_lo_reg[63:32];
        init_state[15] = nonce_hi_reg;
    end

    ccs_block_core u_block_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (core_start),
        .init_state (init_state),
        .done       (core_done),
        .keystream  (keystream)
    );

    // A beat at word position zero needs a fresh block, unless the counter
    // is exhausted, in which case the beat is flagged and carries zero data.
    assign accept     = s_tvalid & s_tready;
    assign need_block = (wp_reg == '0);
    assign overflow   = need_block && (counter_reg == COUNTER_LIMIT);
    assign core_start = accept && need_block && !overflow;
    assign out_free   = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE: begin
                if (accept) state_next = core_start ? CTL_BLOCK : CTL_EMIT;
            end
            CTL_BLOCK: if (core_done) state_next = CTL_EMIT;
            CTL_EMIT:  if (out_free) state_next = CTL_IDLE;
            default:   state_next = CTL_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == CTL_IDLE);
        emit_fire = (state_reg == CTL_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_hold_reg  <= s_tdata[DATA_W-1:0];
            count_hold_reg <= s_tdata[DATA_W+COUNT_W-1:DATA_W];
            last_hold_reg  <= s_tlast;
            ovf_hold_reg   <= overflow;
        end
    end

    // Keystream word for the current position and the mask of valid bytes.
    // Counts of eight or more select every byte, a count of zero none.
    assign ks_word = {keystream[{wp_reg, 1'b1}], keystream[{wp_reg, 1'b0}]};

    always_comb begin
        for (int b = 0; b < BYTES_PER_WORD; b++) begin
            byte_mask[8*b +: 8] = (count_hold_reg > COUNT_W'(b)) ? 8'hFF : 8'h00;
        end
    end

    assign result_data = ovf_hold_reg ? '0 : ((data_hold_reg ^ ks_word) & byte_mask);

    // Word position advances on every beat that used keystream and returns
    // to zero at the end of a message.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else if (emit_fire) begin
            if (last_hold_reg) begin
                wp_reg <= '0;
            end else if (!ovf_hold_reg) begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_data_reg <= result_data;
            m_err_reg  <= ovf_hold_reg;
            m_last_reg <= last_hold_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_err_reg;
    assign m_tlast    = m_last_reg;

    // An overflow beat never carries data.
    a_overflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("overflow beat carries nonzero data");

    // The block core only finishes while the sequencer waits for it.
    a_done_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done |-> (state_reg == CTL_BLOCK))
        else $error("block core finished outside the block wait state");

    // A beat in the middle of a block goes straight to the output stage.
    a_mid_block_no_gen: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && wp_reg != '0) |=> (state_reg == CTL_EMIT))
        else $error("block generation started in the middle of a block");

    // The block counter moves only on a reload or a block start.
    a_counter_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!cfg_write && !core_start) |=> (counter_reg == $past(counter_reg)))
        else $error("block counter changed without a reload or block start");

endmodule
